// ===== design/cba_pkg.sv =====
// Shared types and constants of the contiguous block allocator.
package cba_pkg;

  localparam int StartW   = 10;
  localparam int LenW     = 11;
  localparam int OwnerW   = 8;
  localparam int KbW      = 13;
  localparam int NeedW    = 12;
  localparam int PolicyW  = 2;
  localparam int WasteW   = 2;
  localparam int PoolBlocks = 1024;
  localparam int BlockKb  = 4;

  localparam logic [PolicyW-1:0] PolicyFirst = 2'd0;
  localparam logic [PolicyW-1:0] PolicyBest  = 2'd1;
  localparam logic [PolicyW-1:0] PolicyWorst = 2'd2;
  localparam logic [PolicyW-1:0] PolicyNone  = 2'd3;

  localparam logic FuncAlloc = 1'b0;
  localparam logic FuncFree  = 1'b1;

  // One segment of the address-ordered table.
  typedef struct packed {
    logic              valid;
    logic              is_free;
    logic [StartW-1:0] start;
    logic [LenW-1:0]   len;
    logic [OwnerW-1:0] owner;
  } entry_t;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StDecide,
    StRewrite,
    StDone
  } state_e;

endpackage

// ===== design/cba_req_if.sv =====
// Request channel: valid, ready and the request word.
interface cba_req_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [cba_pkg::OwnerW-1:0]    owner_id;
  logic [cba_pkg::KbW-1:0]       request_kb;

  modport source (output valid, func, owner_id, request_kb, input ready);
  modport sink   (input valid, func, owner_id, request_kb, output ready);
endinterface

// ===== design/cba_rsp_if.sv =====
// Result channel: valid, ready and the result word.
interface cba_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          ok;
  logic [cba_pkg::StartW-1:0]    start_block;
  logic [cba_pkg::LenW-1:0]      blocks_assigned;
  logic [cba_pkg::WasteW-1:0]    slack_kb;
  logic [cba_pkg::LenW-1:0]      free_blocks;
  logic [cba_pkg::LenW-1:0]      largest_hole;

  modport source (output valid, ok, start_block, blocks_assigned, slack_kb, free_blocks,
                  largest_hole, input ready);
  modport sink   (input valid, ok, start_block, blocks_assigned, slack_kb, free_blocks,
                  largest_hole, output ready);
endinterface

// ===== design/cba_cell.sv =====
// One slot of the segment ring; it takes its neighbor's entry on every shift.
module cba_cell #(
  parameter bit IsHead = 1'b0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  cba_pkg::entry_t d_i,
  output cba_pkg::entry_t q_o
);

  cba_pkg::entry_t entry_q, entry_d, rst_val;

  // The head slot starts as one hole over the whole pool.
  always_comb begin
    rst_val         = '0;
    rst_val.valid   = IsHead;
    rst_val.is_free = IsHead;
    rst_val.len     = IsHead ? cba_pkg::LenW'(cba_pkg::PoolBlocks) : '0;
  end

  assign entry_d = shift_i ? d_i : entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= rst_val;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign q_o = entry_q;

endmodule

// ===== design/cba_ctrl.sv =====
// Sequencer at the ring head: scan pass, rewrite pass and result register.
module cba_ctrl #(
  parameter int MaxSegments = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cba_pkg::PolicyW-1:0]   cfg_wdata_i,
  cba_req_if.sink                       req,
  cba_rsp_if.source                     rsp,
  input  cba_pkg::entry_t               head_i,
  input  cba_pkg::entry_t               ahead1_i,
  input  cba_pkg::entry_t               ahead2_i,
  output cba_pkg::entry_t               tail_o,
  output logic                          shift_o
);

  localparam int CntW    = $clog2(MaxSegments);
  localparam int SegCntW = $clog2(MaxSegments + 1);
  localparam int LenW    = cba_pkg::LenW;
  localparam int StartW  = cba_pkg::StartW;
  localparam int NeedW   = cba_pkg::NeedW;
  localparam int KbW     = cba_pkg::KbW;
  localparam int BlockKb = cba_pkg::BlockKb;
  localparam logic [CntW-1:0] LastPos = CntW'(MaxSegments - 1);

  cba_pkg::state_e state_q, state_d;

  logic [cba_pkg::PolicyW-1:0] policy_q;
  logic [SegCntW-1:0]          seg_cnt_q, cnt_acc_q, cnt_acc_d;
  logic [LenW-1:0]             free_tot_q, largest_q, big_q, big_d;
  logic [CntW-1:0]             pos_q;

  // Latched request word.
  logic                        func_q;
  logic [cba_pkg::OwnerW-1:0]  owner_q;
  logic [KbW-1:0]              kb_q;

  // Chosen target segment and its neighbors.
  logic                        tgt_v_q;
  logic [CntW-1:0]             tgt_idx_q;
  logic [LenW-1:0]             tgt_len_q, best_q;
  logic [StartW-1:0]           tgt_start_q;
  logic                        prev_free_q, pf_q, nf_q;
  logic [LenW-1:0]             prev_len_q, plen_q, nlen_q;
  logic                        commit_q;

  // Carry slot for the word pushed back by a split.
  cba_pkg::entry_t             hold_q;

  logic                        out_v_q, out_ok_q;
  logic [StartW-1:0]           out_start_q;
  logic [LenW-1:0]             out_blocks_q, out_free_q, out_big_q;
  logic [cba_pkg::WasteW-1:0]  out_waste_q;

  logic                        accept, last, load_out;
  logic [KbW:0]                kb_round;
  logic [NeedW-1:0]            need;
  logic [KbW:0]                waste_full;
  logic                        pre_ok, hit, take, split, commit;
  logic [LenW-1:0]             merge_len;
  logic [CntW:0]               pos_w, idx_w, mpos_w;
  logic [1:0]                  drop_cnt;
  cba_pkg::entry_t             src, e0, e1, out_e;
  logic                        e0_v, e1_v;

  // Block count, rounding up, and the slack in the last block.
  assign kb_round   = {1'b0, kb_q} + (KbW+1)'(BlockKb - 1);
  assign need       = NeedW'(kb_round / BlockKb);
  assign waste_full = (KbW+1)'(need * BlockKb) - {1'b0, kb_q};
  assign pre_ok     = (kb_q != '0) && (need <= {1'b0, largest_q}) &&
                      (policy_q <= cba_pkg::PolicyWorst);

  assign pos_w = {1'b0, pos_q};
  assign idx_w = {1'b0, tgt_idx_q};
  assign last  = (pos_q == LastPos);
  assign accept = req.valid && req.ready;
  assign load_out = (state_q == cba_pkg::StDone) && (!out_v_q || rsp.ready);

  // Scan pass: does the head word fit the policy, or for a free match the owner.
  always_comb begin
    hit  = head_i.valid && head_i.is_free && ({1'b0, head_i.len} >= need) && pre_ok;
    take = 1'b0;
    if (func_q == cba_pkg::FuncAlloc) begin
      case (policy_q)
        cba_pkg::PolicyFirst: take = hit && !tgt_v_q;
        cba_pkg::PolicyBest:  take = hit && (head_i.len <= best_q);
        cba_pkg::PolicyWorst: take = hit && !tgt_v_q && (head_i.len == largest_q);
        default:              take = 1'b0;
      endcase
    end else begin
      take = head_i.valid && !head_i.is_free && (head_i.owner == owner_q) && !tgt_v_q;
    end
  end

  assign split     = ({1'b0, tgt_len_q} != need);
  assign commit    = tgt_v_q && ((func_q == cba_pkg::FuncFree) || !split ||
                     (seg_cnt_q < SegCntW'(MaxSegments)));
  assign merge_len = tgt_len_q + (nf_q ? nlen_q : '0) + (pf_q ? plen_q : '0);

  // A free keeps the merged hole at the lower of the joined words and drops the rest.
  assign drop_cnt = {1'b0, pf_q} + {1'b0, nf_q};
  assign mpos_w   = idx_w - {{CntW{1'b0}}, pf_q};

  // Words behind a merge move up over the dropped neighbors.
  always_comb begin
    src = head_i;
    if ((func_q == cba_pkg::FuncFree) && (pos_w > mpos_w)) begin
      if (pos_w + (CntW+1)'(drop_cnt) > {1'b0, LastPos}) begin
        src = '0;
      end else begin
        case (drop_cnt)
          2'd1:    src = ahead1_i;
          2'd2:    src = ahead2_i;
          default: src = head_i;
        endcase
      end
    end
  end

  // Rewrite pass: up to two words come out of each word that goes in.
  always_comb begin
    e0   = src;
    e1   = '0;
    e0_v = src.valid;
    e1_v = 1'b0;
    if (!src.valid) begin
      e0_v = 1'b0;
    end else if (func_q == cba_pkg::FuncAlloc) begin
      if (pos_q == tgt_idx_q) begin
        e0.is_free = 1'b0;
        e0.len     = LenW'(need);
        e0.owner   = owner_q;
        if (split) begin
          e1_v       = 1'b1;
          e1.valid   = 1'b1;
          e1.is_free = 1'b1;
          e1.start   = src.start + StartW'(need);
          e1.len     = src.len - LenW'(need);
          e1.owner   = '0;
        end
      end
    end else begin
      if (pos_w == mpos_w) begin
        e0.is_free = 1'b1;
        e0.len     = merge_len;
      end
    end
  end

  // Pick the oldest word for the tail slot; at most one is carried over.
  always_comb begin
    if (hold_q.valid) begin
      out_e = hold_q;
    end else if (e0_v) begin
      out_e = e0;
    end else if (e1_v) begin
      out_e = e1;
    end else begin
      out_e = '0;
    end
  end

  always_comb begin
    cnt_acc_d = cnt_acc_q + SegCntW'(out_e.valid);
    big_d     = (out_e.valid && out_e.is_free && (out_e.len > big_q)) ? out_e.len : big_q;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cba_pkg::StIdle:    if (accept) state_d = cba_pkg::StScan;
      cba_pkg::StScan:    if (last) state_d = cba_pkg::StDecide;
      cba_pkg::StDecide:  state_d = commit ? cba_pkg::StRewrite : cba_pkg::StDone;
      cba_pkg::StRewrite: if (last) state_d = cba_pkg::StDone;
      cba_pkg::StDone:    if (load_out) state_d = cba_pkg::StIdle;
      default:            state_d = cba_pkg::StIdle;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    req.ready = 1'b0;
    shift_o   = 1'b0;
    tail_o    = head_i;
    unique case (state_q)
      cba_pkg::StIdle:    req.ready = 1'b1;
      cba_pkg::StScan:    shift_o = 1'b1;
      cba_pkg::StDecide:  req.ready = 1'b0;
      cba_pkg::StRewrite: begin
        shift_o = 1'b1;
        tail_o  = out_e;
      end
      cba_pkg::StDone:    req.ready = 1'b0;
      default:            req.ready = 1'b0;
    endcase
  end

  // Control state and table summary.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= cba_pkg::StIdle;
      policy_q   <= cba_pkg::PolicyFirst;
      seg_cnt_q  <= SegCntW'(1);
      free_tot_q <= LenW'(cba_pkg::PoolBlocks);
      largest_q  <= LenW'(cba_pkg::PoolBlocks);
      pos_q      <= '0;
      out_v_q    <= 1'b0;
      hold_q     <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        policy_q <= cfg_wdata_i;
      end
      if (shift_o) begin
        pos_q <= last ? '0 : pos_q + 1'b1;
      end
      if (state_q == cba_pkg::StRewrite) begin
        hold_q <= '0;
        if (hold_q.valid && e0_v) begin
          hold_q <= e0;
        end else if ((hold_q.valid || e0_v) && e1_v) begin
          hold_q <= e1;
        end
        if (last) begin
          seg_cnt_q <= cnt_acc_d;
          largest_q <= big_d;
          if (func_q == cba_pkg::FuncAlloc) begin
            free_tot_q <= free_tot_q - LenW'(need);
          end else begin
            free_tot_q <= free_tot_q + tgt_len_q;
          end
        end
      end
      if (load_out) begin
        out_v_q <= 1'b1;
      end else if (rsp.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Request word, scan results and result word.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q      <= req.func;
      owner_q     <= req.owner_id;
      kb_q        <= req.request_kb;
      tgt_v_q     <= 1'b0;
      prev_free_q <= 1'b0;
      pf_q        <= 1'b0;
      nf_q        <= 1'b0;
      best_q      <= largest_q;
    end
    if (state_q == cba_pkg::StScan) begin
      prev_free_q <= head_i.valid && head_i.is_free;
      prev_len_q  <= head_i.len;
      if (take) begin
        tgt_v_q     <= 1'b1;
        tgt_idx_q   <= pos_q;
        tgt_len_q   <= head_i.len;
        tgt_start_q <= head_i.start;
        best_q      <= head_i.len;
        pf_q        <= prev_free_q;
        plen_q      <= prev_len_q;
      end
      if (tgt_v_q && (pos_w == idx_w + 1'b1) && head_i.valid && head_i.is_free) begin
        nf_q   <= 1'b1;
        nlen_q <= head_i.len;
      end
    end
    // The decision waits for the decide state so that a target in the last slot counts.
    if (state_q == cba_pkg::StDecide) begin
      commit_q  <= commit;
      cnt_acc_q <= '0;
      big_q     <= '0;
    end
    if (state_q == cba_pkg::StRewrite) begin
      cnt_acc_q <= cnt_acc_d;
      big_q     <= big_d;
    end
    if (load_out) begin
      out_ok_q     <= commit_q;
      out_start_q  <= commit_q ? tgt_start_q : '0;
      out_blocks_q <= !commit_q ? '0 :
                      (func_q == cba_pkg::FuncAlloc) ? LenW'(need) : tgt_len_q;
      out_waste_q  <= (commit_q && func_q == cba_pkg::FuncAlloc) ? waste_full[1:0] : '0;
      out_free_q   <= free_tot_q;
      out_big_q    <= largest_q;
    end
  end

  assign rsp.valid           = out_v_q;
  assign rsp.ok              = out_ok_q;
  assign rsp.start_block     = out_start_q;
  assign rsp.blocks_assigned = out_blocks_q;
  assign rsp.slack_kb        = out_waste_q;
  assign rsp.free_blocks     = out_free_q;
  assign rsp.largest_hole    = out_big_q;

endmodule

// ===== design/contiguous_block_allocator.sv =====
// Top level of the contiguous block allocator: segment ring and sequencer.
//
// Requests arrive as words on req_i (func, owner_id, request_kb) and each one
// gives exactly one result word on rsp_o. An allocate rounds request_kb up to
// whole blocks and carves the hole chosen by fit_policy (first, best or worst
// fit); a free releases the owner's lowest segment and merges neighbor holes.
// The segment table lives in a ring of MAX_SEGMENTS cells that rotates one
// step per cycle, while scanning or rewriting, past the sequencer at its head.
// Each request takes one full rotation to scan, a decide step and, when the
// table changes, a second rotation to rewrite it. One request is in flight at
// a time; req_i is ready only while idle. The result sits in an output
// register until rsp_o is taken; a stalled receiver holds the next request at
// its final step. fit_policy is written through cfg_we_i / cfg_wdata_i; the
// user must write it only while idle, as the block itself does not enforce
// that. After reset the table holds one hole over the whole pool and
// fit_policy is first fit.
module contiguous_block_allocator #(
  parameter int MAX_SEGMENTS = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [cba_pkg::PolicyW-1:0] cfg_wdata_i,
  cba_req_if.sink                     req_i,
  cba_rsp_if.source                   rsp_o
);

  cba_pkg::entry_t ring [MAX_SEGMENTS];
  cba_pkg::entry_t tail;
  logic            shift;

  // Ring of cells; each takes the word of the cell above it.
  for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
    cba_cell #(.IsHead(i == 0)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .d_i     ((i == MAX_SEGMENTS - 1) ? tail : ring[(i + 1) % MAX_SEGMENTS]),
      .q_o     (ring[i])
    );
  end

  // Sequencer at the head of the ring.
  cba_ctrl #(.MaxSegments(MAX_SEGMENTS)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req         (req_i),
    .rsp         (rsp_o),
    .head_i      (ring[0]),
    .ahead1_i    (ring[1]),
    .ahead2_i    (ring[2]),
    .tail_o      (tail),
    .shift_o     (shift)
  );

endmodule

// ===== test/tb.sv =====
// Testbench for the contiguous block allocator: directed table, random requests, scoreboard.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxSeg = 64;
  localparam int IdleLimit = 20000;
  localparam int StartW = cba_pkg::StartW;
  localparam int LenW = cba_pkg::LenW;
  localparam int WasteW = cba_pkg::WasteW;
  localparam int OwnerW = cba_pkg::OwnerW;
  localparam int KbW = cba_pkg::KbW;
  localparam int PolicyW = cba_pkg::PolicyW;
  localparam int PoolBlocks = cba_pkg::PoolBlocks;
  localparam int BlockKb = cba_pkg::BlockKb;

  typedef struct {
    logic             ok;
    logic [StartW-1:0] start_block;
    logic [LenW-1:0]  blocks_assigned;
    logic [WasteW-1:0] slack_kb;
    logic [LenW-1:0]  free_blocks;
    logic [LenW-1:0]  largest_hole;
  } result_t;

  typedef struct {
    logic              func;
    logic [OwnerW-1:0] owner_id;
    logic [KbW-1:0]    request_kb;
    logic              has_fixed;
    result_t           fixed;
  } req_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [PolicyW-1:0] cfg_wdata_i = '0;

  cba_req_if req_if ();
  cba_rsp_if rsp_if ();

  contiguous_block_allocator u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .req_i(req_if.sink), .rsp_o(rsp_if.source)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the segment table.
  int seg_start [MaxSeg];
  int seg_len [MaxSeg];
  int seg_owner [MaxSeg];
  bit seg_free [MaxSeg];
  int seg_count;
  int pool_free;
  int pool_largest;
  logic [PolicyW-1:0] policy;

  result_t expected_results[$];
  int fail_count = 0;
  bit rx_burst_on = 1'b1;
  bit long_hold_req = 1'b0;
  int idle_cycles = 0;

  function automatic void table_reset();
    seg_start[0] = 0;
    seg_len[0] = PoolBlocks;
    seg_free[0] = 1'b1;
    seg_owner[0] = 0;
    seg_count = 1;
    pool_free = PoolBlocks;
    pool_largest = PoolBlocks;
    policy = cba_pkg::PolicyFirst;
  endfunction

  function automatic void find_largest();
    pool_largest = 0;
    for (int i = 0; i < seg_count; i++)
      if (seg_free[i] && seg_len[i] > pool_largest) pool_largest = seg_len[i];
  endfunction

  function automatic void remove_seg(int idx);
    for (int j = idx; j < seg_count - 1; j++) begin
      seg_start[j] = seg_start[j+1];
      seg_len[j] = seg_len[j+1];
      seg_owner[j] = seg_owner[j+1];
      seg_free[j] = seg_free[j+1];
    end
    seg_count--;
  endfunction

  // Apply one request to the shadow table and return its result word.
  function automatic result_t allocate_or_free(logic func, int owner, int kb);
    result_t r;
    int need;
    int pick;
    int best;
    int i;
    r = '{default: '0};
    if (func == cba_pkg::FuncAlloc) begin
      need = (kb + BlockKb - 1) / BlockKb;
      pick = -1;
      if (kb != 0 && need <= pool_largest && policy <= cba_pkg::PolicyWorst) begin
        best = pool_largest;
        for (i = 0; i < seg_count; i++) begin
          if (!seg_free[i] || seg_len[i] < need) continue;
          if (policy == cba_pkg::PolicyFirst) begin
            pick = i;
            break;
          end else if (policy == cba_pkg::PolicyBest) begin
            if (seg_len[i] <= best) begin
              best = seg_len[i];
              pick = i;
            end
          end else if (seg_len[i] == pool_largest) begin
            pick = i;
            break;
          end
        end
      end
      // A split into a full table is rejected outright.
      if (pick >= 0 && !(seg_len[pick] != need && seg_count >= MaxSeg)) begin
        if (seg_len[pick] != need) begin
          for (int j = seg_count; j > pick; j--) begin
            seg_start[j] = seg_start[j-1];
            seg_len[j] = seg_len[j-1];
            seg_owner[j] = seg_owner[j-1];
            seg_free[j] = seg_free[j-1];
          end
          seg_count++;
          seg_start[pick+1] = seg_start[pick] + need;
          seg_len[pick+1] = seg_len[pick] - need;
          seg_free[pick+1] = 1'b1;
          seg_len[pick] = need;
        end
        seg_free[pick] = 1'b0;
        seg_owner[pick] = owner;
        pool_free -= need;
        find_largest();
        r.ok = 1'b1;
        r.start_block = StartW'(seg_start[pick]);
        r.blocks_assigned = LenW'(need);
        r.slack_kb = WasteW'(need * BlockKb - kb);
      end
    end else begin
      for (i = 0; i < seg_count; i++)
        if (!seg_free[i] && seg_owner[i] == owner) break;
      if (i < seg_count) begin
        r.ok = 1'b1;
        r.start_block = StartW'(seg_start[i]);
        r.blocks_assigned = LenW'(seg_len[i]);
        seg_free[i] = 1'b1;
        pool_free += seg_len[i];
        // Merge with the hole above, then with the hole below.
        if (i + 1 < seg_count && seg_free[i+1]) begin
          seg_len[i] += seg_len[i+1];
          remove_seg(i + 1);
        end
        if (i > 0 && seg_free[i-1]) begin
          seg_len[i-1] += seg_len[i];
          remove_seg(i);
        end
        find_largest();
      end
    end
    r.free_blocks = LenW'(pool_free);
    r.largest_hole = LenW'(pool_largest);
    return r;
  endfunction

  task automatic send_word(req_row_t row, bit allow_gap);
    result_t pred;
    if (allow_gap && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.func <= row.func;
    req_if.owner_id <= row.owner_id;
    req_if.request_kb <= row.request_kb;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    pred = allocate_or_free(row.func, row.owner_id, row.request_kb);
    if (row.has_fixed) pred = row.fixed;
    expected_results.push_back(pred);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (2 * MaxSeg + 10) @(posedge clk_i);
  endtask

  task automatic write_policy(logic [PolicyW-1:0] p);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= p;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    policy = p;
  endtask

  function automatic req_row_t mk(logic f, int o, int kb);
    req_row_t row;
    row = '{func: f, owner_id: OwnerW'(o), request_kb: KbW'(kb), has_fixed: 1'b0,
            fixed: '{default: '0}};
    return row;
  endfunction

  function automatic req_row_t mk_fixed(logic f, int o, int kb, result_t r);
    req_row_t row;
    row = mk(f, o, kb);
    row.has_fixed = 1'b1;
    row.fixed = r;
    return row;
  endfunction

  // Pick a random request, weighted toward sequences that fill and fragment the pool.
  function automatic req_row_t random_word();
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 5)
      return mk(1'($urandom_range(0, 1)), $urandom_range(0, 255), $urandom_range(0, 8191));
    if (kind < 45) return mk(cba_pkg::FuncFree, $urandom_range(0, 63), 0);
    if (kind < 50) return mk(cba_pkg::FuncAlloc, $urandom_range(0, 255), $urandom_range(0, 4096));
    return mk(cba_pkg::FuncAlloc, $urandom_range(0, 63), $urandom_range(1, 160));
  endfunction

  // Receiver: random stall bursts, plus a long hold-off on request.
  initial begin
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (long_hold_req) begin
        rsp_if.ready <= 1'b0;
        repeat (1500) @(posedge clk_i);
        long_hold_req = 1'b0;
      end else if (rx_burst_on && $urandom_range(0, 5) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end else begin
        rsp_if.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Scoreboard and idle watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IdleLimit) begin
        $display("TEST FAILED");
        $finish;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result word");
          fail_count++;
        end else begin
          result_t e;
          e = expected_results.pop_front();
          if (rsp_if.ok !== e.ok) begin
            $error("ok: expected %0d, actual %0d", e.ok, rsp_if.ok); fail_count++;
          end
          if (rsp_if.start_block !== e.start_block) begin
            $error("start_block: expected %0d, actual %0d", e.start_block, rsp_if.start_block);
            fail_count++;
          end
          if (rsp_if.blocks_assigned !== e.blocks_assigned) begin
            $error("blocks_assigned: expected %0d, actual %0d", e.blocks_assigned,
                   rsp_if.blocks_assigned);
            fail_count++;
          end
          if (rsp_if.slack_kb !== e.slack_kb) begin
            $error("slack_kb: expected %0d, actual %0d", e.slack_kb, rsp_if.slack_kb);
            fail_count++;
          end
          if (rsp_if.free_blocks !== e.free_blocks) begin
            $error("free_blocks: expected %0d, actual %0d", e.free_blocks, rsp_if.free_blocks);
            fail_count++;
          end
          if (rsp_if.largest_hole !== e.largest_hole) begin
            $error("largest_hole: expected %0d, actual %0d", e.largest_hole,
                   rsp_if.largest_hole);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    req_row_t directed[$];
    result_t none;
    logic [PolicyW-1:0] sweep[6];
    req_if.valid = 1'b0;
    req_if.func = cba_pkg::FuncAlloc;
    req_if.owner_id = '0;
    req_if.request_kb = '0;
    table_reset();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words; rejected requests on a fresh pool have obvious results.
    none = '{ok: 0, start_block: 0, blocks_assigned: 0, slack_kb: 0,
             free_blocks: PoolBlocks, largest_hole: PoolBlocks};
    directed.push_back(mk_fixed(cba_pkg::FuncAlloc, 8'h00, 0, none));        // zero kilobytes
    directed.push_back(mk_fixed(cba_pkg::FuncFree, 8'hFF, 13'h1FFF, none));  // unknown owner
    directed.push_back(mk_fixed(cba_pkg::FuncAlloc, 8'hAA, 13'h1FFF, none)); // beyond the pool
    directed.push_back(mk_fixed(cba_pkg::FuncAlloc, 8'h55, 4097, none));
    directed.push_back(mk_fixed(cba_pkg::FuncAlloc, 1, 4096, '{ok: 1, start_block: 0,
      blocks_assigned: PoolBlocks, slack_kb: 0, free_blocks: 0, largest_hole: 0}));
    directed.push_back(mk(cba_pkg::FuncAlloc, 2, 1));                        // pool full
    directed.push_back(mk_fixed(cba_pkg::FuncFree, 1, 0, '{ok: 1, start_block: 0,
      blocks_assigned: PoolBlocks, slack_kb: 0, free_blocks: PoolBlocks,
      largest_hole: PoolBlocks}));
    directed.push_back(mk(cba_pkg::FuncAlloc, 3, 1));
    directed.push_back(mk(cba_pkg::FuncAlloc, 4, 5));
    directed.push_back(mk(cba_pkg::FuncAlloc, 3, 7));                        // owner holds two
    directed.push_back(mk(cba_pkg::FuncAlloc, 5, 40));
    directed.push_back(mk(cba_pkg::FuncAlloc, 6, 2));
    directed.push_back(mk(cba_pkg::FuncFree, 4, 0));
    directed.push_back(mk(cba_pkg::FuncFree, 6, 0));
    directed.push_back(mk(cba_pkg::FuncFree, 3, 0));       // lowest segment of owner
    directed.push_back(mk(cba_pkg::FuncFree, 3, 0));
    directed.push_back(mk(cba_pkg::FuncFree, 5, 0));
    foreach (directed[k]) send_word(directed[k], 1'b1);

    // Fill the table with one-block segments to hit the split limit.
    write_policy(cba_pkg::PolicyBest);
    for (int k = 0; k < 70; k++) send_word(mk(cba_pkg::FuncAlloc, 100 + (k % 2), 4), 1'b0);
    for (int k = 0; k < 40; k++) send_word(mk(cba_pkg::FuncFree, 100, 0), 1'b0);

    // Random phases over each policy, the unused code among them.
    sweep = '{cba_pkg::PolicyWorst, cba_pkg::PolicyFirst, cba_pkg::PolicyNone,
              cba_pkg::PolicyBest, cba_pkg::PolicyWorst, cba_pkg::PolicyFirst};
    foreach (sweep[p]) begin
      write_policy(sweep[p]);
      if (p == 1) long_hold_req = 1'b1;
      for (int k = 0; k < (sweep[p] == cba_pkg::PolicyNone ? 60 : 200); k++)
        send_word(random_word(), 1'b1);
      if (p == 2) drain();
    end

    // Last stretch with no idling on either side.
    rx_burst_on = 1'b0;
    for (int k = 0; k < 60; k++) send_word(random_word(), 1'b0);
    drain();
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end
endmodule
